// ===== rtl/fbr_pkg.sv =====
// shared types, codes and constants of the frame buffer register block
package fbr_pkg;

	// request kinds
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// capture kinds
	localparam logic [1:0] CAP_NONE = 2'd0;
	localparam logic [1:0] CAP_8    = 2'd1;
	localparam logic [1:0] CAP_24   = 2'd2;

	// register map by byte offset
	localparam logic [10:0] OFS_CTRL   = 11'h000;
	localparam logic [10:0] OFS_BUF    = 11'h004;
	localparam logic [10:0] OFS_CAMBUF = 11'h008;
	localparam logic [10:0] OFS_CAMPOS = 11'h00c;

	localparam logic [31:0] FRAME_PERIOD_RST = 32'd400000;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_PDIV,
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_RESP
	} fbr_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [10:0] reg_offset;
		logic [31:0] write_data;
	} fbr_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_offset;
		logic [1:0]  capture_event;
		logic [15:0] picture_number;
		logic [9:0]  window_x;
		logic [22:0] window_y;
	} fbr_out_t;

	typedef struct packed {
		logic        rd_en;
		logic        wr_en;
		logic [31:0] wr_data;
	} fbr_pal_cmd_t;

endpackage

// ===== rtl/fbr_palette.sv =====
// palette memory with a gray ramp fill pass after reset
module fbr_palette #(
	parameter int ENTRIES = 256,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fbr_pkg::fbr_pal_cmd_t cmd,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	output logic [31:0]          rd_data,
	output logic                 ready
);

	logic [31:0]   mem [ENTRIES];
	logic [31:0]   rd_q;
	logic          init_q;
	logic [AW-1:0] cnt_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;
	logic [31:0]   ramp;

	// entry i resets to i * 0x010101
	assign ramp = 32'(cnt_q) + (32'(cnt_q) << 8) + (32'(cnt_q) << 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
			cnt_q  <= '0;
		end else if (init_q) begin
			cnt_q <= cnt_q + AW'(1);
			if (cnt_q == AW'(ENTRIES - 1)) begin
				init_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = init_q || cmd.wr_en;
		wa = init_q ? cnt_q : wr_addr;
		wd = init_q ? ramp : cmd.wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign ready   = !init_q;

endmodule

// ===== rtl/fbr_div.sv =====
// divider by one of two constants through reciprocal multiplication, three stages
module fbr_div #(
	parameter int DW    = 10,
	parameter int DIV_A = 640,
	parameter int DIV_B = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          sel_b,
	input  logic [31:0]   dividend,
	output logic          done,
	output logic [31:0]   quot,
	output logic [DW-1:0] rem
);

	// q = (x * ceil(2^(32+l) / d)) >> (32+l) with l = ceil(log2 d) is exact for 32-bit x
	localparam int          SH_A  = 32 + $clog2(DIV_A);
	localparam int          SH_B  = 32 + $clog2(DIV_B);
	localparam logic [32:0] RCP_A = 33'(((64'd1 << SH_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A));
	localparam logic [32:0] RCP_B = 33'(((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B));
	localparam logic [31:0] DVS_A = 32'(DIV_A);
	localparam logic [31:0] DVS_B = 32'(DIV_B);

	logic          v_s1;
	logic          v_s2;
	logic          done_q;
	logic          sel_s1;
	logic          sel_s2;
	logic [31:0]   x_s1;
	logic [31:0]   x_s2;
	logic [64:0]   prod_s1;
	logic [31:0]   quot_s2;
	logic [31:0]   quot_q;
	logic [DW-1:0] rem_q;
	logic [31:0]   back;

	assign back = quot_s2 * (sel_s2 ? DVS_B : DVS_A);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= 65'(dividend) * 65'(sel_b ? RCP_B : RCP_A);
			x_s1    <= dividend;
			sel_s1  <= sel_b;
		end
		if (v_s1) begin
			quot_s2 <= sel_s1 ? 32'(prod_s1 >> SH_B) : 32'(prod_s1 >> SH_A);
			x_s2    <= x_s1;
			sel_s2  <= sel_s1;
		end
		if (v_s2) begin
			quot_q <= quot_s2;
			rem_q  <= DW'(x_s2 - back);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/framebuffer_register_block.sv =====
// Frame buffer register block: bus reads and writes of control, buffer base, camera buffer
// base, camera position and a palette at 0x400, plus clock ticks that run the refresh
// timing. After reset the palette is filled with a gray ramp, and the short refresh interval
// is then computed before the first beat can be taken. A read, write or tick is accepted
// into the item register and then executed into the output register once that is free.
// A camera position write also runs the shared three-stage reciprocal divider, which
// produces the window column and row, before its response is registered. A frame_period
// write holds the input stalled while the same divider recomputes the short interval.
module framebuffer_register_block #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int LINE_PIXELS     = 640,
	parameter int REFRESH_DIV     = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  fbr_pkg::fbr_in_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output fbr_pkg::fbr_out_t out_data
);

	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam int DVS_MAX = (LINE_PIXELS > REFRESH_DIV) ? LINE_PIXELS : REFRESH_DIV;
	localparam int DW = $clog2(DVS_MAX + 1);
	localparam logic [31:0] PAL_LIMIT = 32'(PALETTE_ENTRIES);

	fbr_pkg::fbr_state_t state_q, state_d;

	fbr_pkg::fbr_in_t  item_s1;
	fbr_pkg::fbr_out_t out_q;
	fbr_pkg::fbr_out_t res;
	logic              out_valid_q;

	logic [31:0] frame_period_q;
	logic [31:0] short_q;
	logic        pend_q;
	logic [31:0] control_q;
	logic [31:0] buffer_base_q;
	logic [31:0] camera_base_q;
	logic [31:0] camera_pos_q;
	logic [9:0]  window_x_q;
	logic [22:0] window_y_q;
	logic [31:0] counter_q;
	logic        phase_q;
	logic        in_refresh_q;
	logic [6:0]  tally_q;
	logic [15:0] picture_q;

	logic accept;
	logic out_free;
	logic exec_fire;
	logic resp_fire;
	logic is_read;
	logic is_write;
	logic is_tick;
	logic is_campos_wr;
	logic pal_hit;
	logic reg_hit;
	logic tick_end;

	fbr_pkg::fbr_pal_cmd_t pal_cmd;
	logic [31:0]           pal_rd_data;
	logic                  pal_ready;

	logic          div_start;
	logic [31:0]   div_dividend;
	logic          div_sel_b;
	logic          div_done;
	logic [31:0]   div_quot;
	logic [DW-1:0] div_rem;

	fbr_palette #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pal_cmd),
		.rd_addr(PAL_AW'(in_data.reg_offset[9:2])),
		.wr_addr(PAL_AW'(item_s1.reg_offset[9:2])),
		.rd_data(pal_rd_data),
		.ready  (pal_ready)
	);

	// divisor a is the line width, divisor b the refresh divider
	fbr_div #(
		.DW   (DW),
		.DIV_A(LINE_PIXELS),
		.DIV_B(REFRESH_DIV)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sel_b   (div_sel_b),
		.dividend(div_dividend),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// decode of the item being executed
	always_comb begin
		is_read  = item_s1.req_type == fbr_pkg::REQ_READ;
		is_write = item_s1.req_type == fbr_pkg::REQ_WRITE;
		is_tick  = item_s1.req_type == fbr_pkg::REQ_TICK;
		reg_hit  = item_s1.reg_offset == fbr_pkg::OFS_CTRL
			|| item_s1.reg_offset == fbr_pkg::OFS_BUF
			|| item_s1.reg_offset == fbr_pkg::OFS_CAMBUF
			|| item_s1.reg_offset == fbr_pkg::OFS_CAMPOS;
		pal_hit  = item_s1.reg_offset[10] && ({24'd0, item_s1.reg_offset[9:2]} < PAL_LIMIT);
		is_campos_wr = is_write && item_s1.reg_offset == fbr_pkg::OFS_CAMPOS;
		tick_end = counter_q < 32'd2;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == fbr_pkg::ST_IDLE && !pend_q && !cfg_we);
	assign accept   = in_valid && !in_stall;

	// result of the executed item
	always_comb begin
		res = '0;
		res.window_x = window_x_q;
		res.window_y = window_y_q;
		if (is_read) begin
			unique case (item_s1.reg_offset)
				fbr_pkg::OFS_CTRL:   res.read_data = {in_refresh_q, tally_q, control_q[23:0]};
				fbr_pkg::OFS_BUF:    res.read_data = buffer_base_q;
				fbr_pkg::OFS_CAMBUF: res.read_data = camera_base_q;
				fbr_pkg::OFS_CAMPOS: res.read_data = camera_pos_q;
				default: begin
					if (pal_hit) begin
						res.read_data = pal_rd_data;
					end else begin
						res.bad_offset = 1'b1;
					end
				end
			endcase
		end else if (is_write) begin
			res.bad_offset = !reg_hit && !pal_hit;
		end else if (is_tick) begin
			if (tick_end && phase_q && control_q[0]) begin
				res.capture_event  = control_q[1] ? fbr_pkg::CAP_24 : fbr_pkg::CAP_8;
				res.picture_number = picture_q;
			end
		end
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		exec_fire    = 1'b0;
		resp_fire    = 1'b0;
		div_start    = 1'b0;
		div_dividend = frame_period_q;
		div_sel_b    = 1'b1;
		unique case (state_q)
			fbr_pkg::ST_INIT: begin
				if (pal_ready) begin
					state_d = fbr_pkg::ST_IDLE;
				end
			end
			fbr_pkg::ST_IDLE: begin
				if (pend_q && !cfg_we) begin
					div_start = 1'b1;
					state_d   = fbr_pkg::ST_PDIV;
				end else if (accept) begin
					state_d = fbr_pkg::ST_EXEC;
				end
			end
			fbr_pkg::ST_PDIV: begin
				if (div_done) begin
					state_d = fbr_pkg::ST_IDLE;
				end
			end
			fbr_pkg::ST_EXEC: begin
				div_dividend = item_s1.write_data;
				div_sel_b    = 1'b0;
				if (is_campos_wr) begin
					div_start = 1'b1;
					state_d   = fbr_pkg::ST_DIV;
				end else if (out_free) begin
					exec_fire = 1'b1;
					state_d   = fbr_pkg::ST_IDLE;
				end
			end
			fbr_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = fbr_pkg::ST_RESP;
				end
			end
			fbr_pkg::ST_RESP: begin
				if (out_free) begin
					resp_fire = 1'b1;
					state_d   = fbr_pkg::ST_IDLE;
				end
			end
			default: state_d = fbr_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		pal_cmd.rd_en   = accept;
		pal_cmd.wr_en   = exec_fire && is_write && pal_hit;
		pal_cmd.wr_data = item_s1.write_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbr_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// period register and the short interval derived from it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= fbr_pkg::FRAME_PERIOD_RST;
			pend_q         <= 1'b1;
			short_q        <= 32'd1;
		end else begin
			if (cfg_we) begin
				frame_period_q <= cfg_wdata;
				pend_q         <= 1'b1;
			end else if (div_start && state_q == fbr_pkg::ST_IDLE) begin
				pend_q <= 1'b0;
			end
			if (state_q == fbr_pkg::ST_PDIV && div_done) begin
				short_q <= (div_quot == 32'd0) ? 32'd1 : div_quot;
			end
		end
	end

	// bus registers and refresh timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q     <= '0;
			buffer_base_q <= '0;
			camera_base_q <= '0;
			camera_pos_q  <= '0;
			window_x_q    <= '0;
			window_y_q    <= '0;
			counter_q     <= fbr_pkg::FRAME_PERIOD_RST;
			phase_q       <= 1'b0;
			in_refresh_q  <= 1'b1;
			tally_q       <= '0;
			picture_q     <= '0;
		end else begin
			if (state_q == fbr_pkg::ST_EXEC && is_campos_wr) begin
				camera_pos_q <= item_s1.write_data;
			end
			if (state_q == fbr_pkg::ST_DIV && div_done) begin
				window_x_q <= 10'(div_rem);
				window_y_q <= 23'(div_quot);
			end
			if (exec_fire && is_write) begin
				unique case (item_s1.reg_offset)
					fbr_pkg::OFS_CTRL:   control_q     <= item_s1.write_data;
					fbr_pkg::OFS_BUF:    buffer_base_q <= item_s1.write_data;
					fbr_pkg::OFS_CAMBUF: camera_base_q <= item_s1.write_data;
					default: ;
				endcase
			end
			if (exec_fire && is_tick) begin
				if (!tick_end) begin
					counter_q <= counter_q - 32'd1;
				end else begin
					counter_q <= short_q;
					if (phase_q) begin
						if (control_q[0]) begin
							picture_q <= picture_q + 16'd1;
						end
						phase_q      <= 1'b0;
						in_refresh_q <= 1'b0;
					end else begin
						tally_q      <= tally_q + 7'd1;
						phase_q      <= 1'b1;
						in_refresh_q <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire || resp_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire || resp_fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
